[hw/rtl/ctba_pkg.sv]
// Shared constants, types and register codes of the conductivity/TDS averager.
`timescale 1ns / 1ps

package ctba_pkg;

  // Block averaging
  localparam int SAMPLES = 20;
  localparam int COUNT_W = 6;
  localparam int SUM_W   = 16;

  // Field widths
  localparam int ADC_W   = 10;
  localparam int TEMP_W  = 12;
  localparam int RES_W   = 16;

  // Averaging divisor: SAMPLES full-scale codes, with half of it for rounding
  localparam int AVG_DIV  = SAMPLES * 1023;
  localparam int AVG_HALF = AVG_DIV / 2;
  localparam int FULL_MV  = 3300;

  // Compensation: 1.0 in units of 1/10000 per 1/16 degree
  localparam int COMP_ONE = 160000;
  localparam int TDS_DIV  = 10000;
  localparam int TEMP_REF = 400;
  localparam int TEMP_MIN = -160;

  // Working widths
  localparam int MV_W    = 18;
  localparam int DEN_W   = 22;
  localparam int PROD_W  = 34;

  // Bit-serial divider
  localparam int DIV_NW  = 42;
  localparam int DIV_DW  = 22;
  localparam int DIV_QW  = 18;
  localparam int DIV_SW  = $clog2(DIV_QW);

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_EC_GAIN     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEF   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_EC_FLOOR_MV = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TDS_FACTOR  = CFG_IDX_W'(3);

  typedef struct packed {
    logic [15:0] ec_gain;
    logic [9:0]  temp_coef;
    logic [11:0] ec_floor_mv;
    logic [15:0] tds_factor;
  } cfg_regs_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] num;
    logic [DIV_DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              ovf;
    logic [DIV_QW-1:0] quo;
  } div_rsp_t;

endpackage

[hw/rtl/ctba_ifs.sv]
// Handshake channels: input words, result words and configuration writes.
`timescale 1ns / 1ps

interface ctba_item_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 func;
  logic [ctba_pkg::ADC_W-1:0]           adc_sample;
  logic signed [ctba_pkg::TEMP_W-1:0]   temperature;

  modport source (output valid, func, adc_sample, temperature, input ready);
  modport sink (input valid, func, adc_sample, temperature, output ready);
endinterface

interface ctba_result_if;
  logic                        valid;
  logic                        ready;
  logic [ctba_pkg::RES_W-1:0]  ec_value;
  logic [ctba_pkg::RES_W-1:0]  tds_value;

  modport source (output valid, ec_value, tds_value, input ready);
  modport sink (input valid, ec_value, tds_value, output ready);
endinterface

interface ctba_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ctba_pkg::CFG_IDX_W-1:0]   index;
  logic [ctba_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/ctba_cfg.sv]
// Configuration register file with reset defaults.
`timescale 1ns / 1ps

module ctba_cfg (
  input  logic               clk,
  input  logic               rst,
  ctba_cfg_if.sink           cfg,
  output ctba_pkg::cfg_regs_t regs
);

  // Writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.ec_gain     <= 16'd4012;
      regs.temp_coef   <= 10'd190;
      regs.ec_floor_mv <= 12'd50;
      regs.tds_factor  <= 16'd43776;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        ctba_pkg::REG_EC_GAIN:     regs.ec_gain     <= cfg.data;
        ctba_pkg::REG_TEMP_COEF:   regs.temp_coef   <= cfg.data[9:0];
        ctba_pkg::REG_EC_FLOOR_MV: regs.ec_floor_mv <= cfg.data[11:0];
        ctba_pkg::REG_TDS_FACTOR:  regs.tds_factor  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

[hw/rtl/ctba_serdiv.sv]
// Bit-serial restoring divider, one quotient bit per cycle, with overflow flag.
`timescale 1ns / 1ps

module ctba_serdiv (
  input  logic                clk,
  input  logic                rst,
  input  ctba_pkg::div_req_t  req,
  output ctba_pkg::div_rsp_t  rsp
);

  localparam int HI_W = ctba_pkg::DIV_NW - ctba_pkg::DIV_QW;

  logic                           busy;
  logic                           chk;
  logic                           done;
  logic                           ovf;
  logic [ctba_pkg::DIV_SW-1:0]    step;
  logic [HI_W-1:0]                rem;
  logic [ctba_pkg::DIV_QW-1:0]    lo;
  logic [ctba_pkg::DIV_DW-1:0]    den_q;

  logic [ctba_pkg::DIV_DW:0]      trial;
  logic [ctba_pkg::DIV_DW:0]      diff;
  logic                           ge;

  // One restoring step: bring down the next numerator bit
  always_comb begin
    trial = {rem[ctba_pkg::DIV_DW-1:0], lo[ctba_pkg::DIV_QW-1]};
    ge    = trial >= {1'b0, den_q};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      chk  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        chk   <= 1'b1;
        step  <= '0;
        rem   <= req.num[ctba_pkg::DIV_NW-1:ctba_pkg::DIV_QW];
        lo    <= req.num[ctba_pkg::DIV_QW-1:0];
        den_q <= req.den;
      end else if (busy && chk) begin
        // quotient does not fit when the top part already reaches the divisor
        ovf <= rem >= HI_W'(den_q);
        chk <= 1'b0;
      end else if (busy) begin
        rem  <= HI_W'(ge ? diff[ctba_pkg::DIV_DW-1:0] : trial[ctba_pkg::DIV_DW-1:0]);
        lo   <= {lo[ctba_pkg::DIV_QW-2:0], ge};
        step <= step + 1'b1;
        if (step == ctba_pkg::DIV_SW'(ctba_pkg::DIV_QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.ovf  = ovf;
  assign rsp.quo  = lo;

  a_no_restart: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("divider done without a pass");

endmodule

[hw/rtl/conductivity_tds_block_averager.sv]
// Top level: sample averaging, temperature hold, result sequencer and output register.
`timescale 1ns / 1ps

// Temperature words and samples that do not complete a block are taken at once
// while idle. The sample that completes a block of SAMPLES starts a result pass
// during which no input word is taken. The pass is set by up to three runs of
// the shared bit-serial divider (each run: one overflow check and 18 quotient
// bits, then the quotient is handed back) for the millivolt average, TDS and
// EC, plus eight sequencing and multiply steps. EC skips its divider run when it
// reads zero or saturates at zero compensation. Finished results sit in an
// output register, so new words are taken while a result waits to be read; a
// pass that finishes while the previous result is still unread holds in its
// last step until that result is taken.
module conductivity_tds_block_averager (
  input  logic          clk,
  input  logic          rst,
  ctba_item_if.sink     item,
  ctba_result_if.source result,
  ctba_cfg_if.sink      cfg
);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_MV   = 12'b0000_0000_0010,
    S_MVW  = 12'b0000_0000_0100,
    S_DEN  = 12'b0000_0000_1000,
    S_TDS  = 12'b0000_0001_0000,
    S_TDSW = 12'b0000_0010_0000,
    S_PA   = 12'b0000_0100_0000,
    S_PB   = 12'b0000_1000_0000,
    S_ECP  = 12'b0001_0000_0000,
    S_EC   = 12'b0010_0000_0000,
    S_ECW  = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_t;

  localparam logic signed [ctba_pkg::TEMP_W-1:0] TEMP_MIN_S =
    ctba_pkg::TEMP_W'(ctba_pkg::TEMP_MIN);
  localparam logic signed [ctba_pkg::TEMP_W-1:0] TEMP_RST =
    ctba_pkg::TEMP_W'(ctba_pkg::TEMP_REF);
  localparam logic [ctba_pkg::RES_W-1:0] RES_MAX = '1;

  state_t                               state;
  ctba_pkg::cfg_regs_t                  regs;
  ctba_pkg::div_req_t                   div_req;
  ctba_pkg::div_rsp_t                   div_rsp;

  logic [ctba_pkg::SUM_W-1:0]           sample_sum;
  logic [ctba_pkg::COUNT_W-1:0]         sample_count;
  logic signed [ctba_pkg::TEMP_W-1:0]   kept_temperature;

  logic [ctba_pkg::MV_W-1:0]            mv;
  logic signed [ctba_pkg::DEN_W-1:0]    den;
  logic [ctba_pkg::PROD_W-1:0]          tds_num;
  logic [ctba_pkg::PROD_W-1:0]          ec_prod;
  logic [35:0]                          lhs;
  logic [32:0]                          rhs;
  logic [ctba_pkg::RES_W-1:0]           ec;
  logic [ctba_pkg::RES_W-1:0]           tds;

  logic                                 out_valid;
  logic [ctba_pkg::RES_W-1:0]           ec_out;
  logic [ctba_pkg::RES_W-1:0]           tds_out;

  logic                                 take;
  logic                                 load_out;
  logic [ctba_pkg::SUM_W-1:0]           sum_next;
  logic [ctba_pkg::COUNT_W-1:0]         count_next;
  logic [27:0]                          mv_num;
  logic signed [12:0]                   t_diff;
  logic signed [23:0]                   den_full;
  logic [ctba_pkg::DIV_NW-1:0]          ec_num;
  logic                                 den_neg;
  logic                                 den_zero;

  // Saturate an 18-bit quotient to the 16-bit result range
  function automatic logic [ctba_pkg::RES_W-1:0] sat_res(
    input logic ovf,
    input logic [ctba_pkg::DIV_QW-1:0] q
  );
    logic big;
    big = ovf || (q[ctba_pkg::DIV_QW-1:ctba_pkg::RES_W] != '0);
    return big ? RES_MAX : q[ctba_pkg::RES_W-1:0];
  endfunction

  ctba_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ctba_serdiv u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Handshake
  assign item.ready       = (state == S_IDLE);
  assign take             = item.valid && item.ready;
  assign load_out         = (state == S_DONE) && (!out_valid || result.ready);
  assign result.valid     = out_valid;
  assign result.ec_value  = ec_out;
  assign result.tds_value = tds_out;

  // Arithmetic feeding the sequencer
  always_comb begin
    sum_next   = sample_sum + ctba_pkg::SUM_W'(item.adc_sample);
    count_next = sample_count + 1'b1;
    mv_num     = 28'(sample_sum) * 28'(ctba_pkg::FULL_MV) + 28'(ctba_pkg::AVG_HALF);
    t_diff     = 13'(kept_temperature) - 13'(ctba_pkg::TEMP_REF);
    den_full   = 24'(signed'({1'b0, regs.temp_coef})) * 24'(t_diff)
                 + 24'(ctba_pkg::COMP_ONE);
    ec_num     = ctba_pkg::DIV_NW'({ec_prod, 7'b0}) + ctba_pkg::DIV_NW'({ec_prod, 5'b0});
    den_neg    = den[ctba_pkg::DEN_W-1];
    den_zero   = (den == '0);
  end

  // Divider requests
  always_comb begin
    div_req = '0;
    case (state)
      S_MV: begin
        div_req.start = 1'b1;
        div_req.num   = ctba_pkg::DIV_NW'(mv_num);
        div_req.den   = ctba_pkg::DIV_DW'(ctba_pkg::AVG_DIV);
      end
      S_TDS: begin
        div_req.start = 1'b1;
        div_req.num   = ctba_pkg::DIV_NW'(tds_num);
        div_req.den   = ctba_pkg::DIV_DW'(ctba_pkg::TDS_DIV);
      end
      S_EC: begin
        div_req.start = !den_neg && !den_zero && (lhs > 36'(rhs));
        div_req.num   = ec_num;
        div_req.den   = ctba_pkg::DIV_DW'(den);
      end
      default: ;
    endcase
  end

  // Control: accumulation, temperature hold, sequencer, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      sample_sum       <= '0;
      sample_count     <= '0;
      kept_temperature <= TEMP_RST;
      out_valid        <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (take && item.func) begin
            if (item.temperature >= TEMP_MIN_S) begin
              kept_temperature <= item.temperature;
            end
          end else if (take) begin
            sample_sum   <= sum_next;
            sample_count <= count_next;
            if (count_next >= ctba_pkg::COUNT_W'(ctba_pkg::SAMPLES)) begin
              state <= S_MV;
            end
          end
        end
        S_MV: begin
          sample_sum   <= '0;
          sample_count <= '0;
          state        <= S_MVW;
        end
        S_MVW: begin
          if (div_rsp.done) begin
            state <= S_DEN;
          end
        end
        S_DEN:  state <= S_TDS;
        S_TDS:  state <= S_TDSW;
        S_TDSW: begin
          if (div_rsp.done) begin
            state <= S_PA;
          end
        end
        S_PA:   state <= S_PB;
        S_PB:   state <= S_ECP;
        S_ECP:  state <= S_EC;
        S_EC:   state <= div_req.start ? S_ECW : S_DONE;
        S_ECW: begin
          if (div_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_MVW && div_rsp.done) begin
      mv <= div_rsp.quo;
    end
    if (state == S_DEN) begin
      den     <= den_full[ctba_pkg::DEN_W-1:0];
      tds_num <= ctba_pkg::PROD_W'(mv) * ctba_pkg::PROD_W'(regs.tds_factor);
    end
    if (state == S_TDSW && div_rsp.done) begin
      tds <= sat_res(div_rsp.ovf, div_rsp.quo);
    end
    if (state == S_PA) begin
      lhs <= 36'(mv) * 36'(ctba_pkg::COMP_ONE);
    end
    if (state == S_PB) begin
      rhs <= 33'(regs.ec_floor_mv) * 33'(den[ctba_pkg::DEN_W-2:0]);
    end
    if (state == S_ECP) begin
      ec_prod <= ctba_pkg::PROD_W'(regs.ec_gain) * ctba_pkg::PROD_W'(mv);
    end
    // EC: negative compensation or floor gives zero, zero compensation saturates unless mv is zero
    if (state == S_EC && !div_req.start) begin
      if (!den_neg && den_zero && mv != '0) begin
        ec <= RES_MAX;
      end else begin
        ec <= '0;
      end
    end
    if (state == S_ECW && div_rsp.done) begin
      ec <= sat_res(div_rsp.ovf, div_rsp.quo);
    end
    if (load_out) begin
      ec_out  <= ec;
      tds_out <= tds;
    end
  end

  a_idle_div_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while idle");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (sample_count < ctba_pkg::COUNT_W'(ctba_pkg::SAMPLES)))
    else $error("sample count passed the block size");
  a_temp_floor: assert property (@(posedge clk) disable iff (rst)
    kept_temperature >= TEMP_MIN_S)
    else $error("kept temperature below the cold limit");
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    load_out |=> result.valid)
    else $error("finished result not presented");

endmodule
